// ----- hdl/md5_pkg.sv -----
// ---------------------------------------------------------------------------
// md5 package
// types, round constants and shift amounts shared by the md5 hasher
// ---------------------------------------------------------------------------
package md5_pkg;

    localparam int WORD_W   = 32;
    localparam int BLK_DEPTH = 16;
    localparam int BLK_AW   = 4;
    localparam int COUNT_W  = 61;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hEFCDAB89;
    localparam logic [31:0] IV_C = 32'h98BADCFE;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LAST_POS = 6'h3F;
    localparam logic [5:0] MAX_TAIL = 6'd55;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN_LO,
        ST_LEN_HI,
        ST_COMP,
        ST_OUT
    } state_t;

    // start request and busy status of the compression unit
    typedef struct packed {
        logic start;
        logic busy;
    } comp_ctl_t;

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        begin
            case (r)
                6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
                6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
                6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
                6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
                6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
                6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
                6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
                6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
                6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
                6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
                6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
                6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
                6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
                6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
                6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
                6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
                6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
                6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
                6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
                6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
                6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
                6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
                6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
            endcase
            return k;
        end
    endfunction

    function automatic logic [4:0] round_s(input logic [5:0] r);
        logic [4:0] s;
        begin
            case ({r[5:4], r[1:0]})
                4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
                4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
                4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
                4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
            endcase
            return s;
        end
    endfunction

    // message word used by a round
    function automatic logic [3:0] round_idx(input logic [5:0] r);
        logic [3:0] i;
        begin
            case (r[5:4])
                2'd0: i = r[3:0];
                2'd1: i = 4'(5 * r[3:0] + 1);
                2'd2: i = 4'(3 * r[3:0] + 5);
                default: i = 4'(7 * r[3:0]);
            endcase
            return i;
        end
    endfunction

endpackage

// ----- hdl/md5_ram.sv -----
// ---------------------------------------------------------------------------
// md5 ram
// generic single-port-write, registered-read memory
// ---------------------------------------------------------------------------
module md5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// ----- hdl/md5_round.sv -----
// ---------------------------------------------------------------------------
// md5 round unit
// runs the 64 rounds one per cycle and folds the result into the chain
// ---------------------------------------------------------------------------
module md5_round (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 reinit,
    input  logic [31:0]          word,
    output logic [3:0]           word_addr,
    output logic                 done,
    output md5_pkg::comp_ctl_t   ctl,
    output logic [127:0]         chain
);
    logic [31:0] ha_reg, hb_reg, hc_reg, hd_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        fin_reg;
    logic [5:0]  r;
    logic [5:0]  r_next;
    logic [31:0] f, t, rot;

    // round r uses word fetched in previous cycle; cnt counts address issue
    assign r = cnt_reg[5:0] - 6'd1;
    assign r_next = busy_reg ? cnt_reg[5:0] : 6'd0;
    assign word_addr = md5_pkg::round_idx(r_next);

    always_comb
    begin
        case (r[5:4])
            2'd0: f = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1: f = (d_reg & b_reg) | (~d_reg & c_reg);
            2'd2: f = b_reg ^ c_reg ^ d_reg;
            default: f = c_reg ^ (b_reg | ~d_reg);
        endcase
        t = a_reg + f + word + md5_pkg::round_k(r);
        rot = (t << md5_pkg::round_s(r)) | (t >> (6'd32 - {1'b0, md5_pkg::round_s(r)}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            fin_reg  <= 1'b0;
            ha_reg <= md5_pkg::IV_A;
            hb_reg <= md5_pkg::IV_B;
            hc_reg <= md5_pkg::IV_C;
            hd_reg <= md5_pkg::IV_D;
        end
        else
        begin
            fin_reg <= 1'b0;
            if (reinit)
            begin
                ha_reg <= md5_pkg::IV_A;
                hb_reg <= md5_pkg::IV_B;
                hc_reg <= md5_pkg::IV_C;
                hd_reg <= md5_pkg::IV_D;
            end
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd1;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == 7'd64)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                    ha_reg <= ha_reg + d_reg;
                    hb_reg <= hb_reg + b_reg + rot;
                    hc_reg <= hc_reg + b_reg;
                    hd_reg <= hd_reg + c_reg;
                end
                cnt_reg <= cnt_reg + 7'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            a_reg <= ha_reg;
            b_reg <= hb_reg;
            c_reg <= hc_reg;
            d_reg <= hd_reg;
        end
        else if (busy_reg)
        begin
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= b_reg + rot;
        end
    end

    assign done = fin_reg;
    assign ctl.start = start;
    assign ctl.busy = busy_reg;
    assign chain = {hd_reg, hc_reg, hb_reg, ha_reg};
endmodule

// ----- hdl/md5_message_digest.sv -----
// ---------------------------------------------------------------------------
// md5 message digest
// streaming md5 hasher, one message byte per transaction
// ---------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_stall) carries data_byte, has_byte and
//   end_of_message. bytes are packed little-endian into a 16-word block
//   memory; each byte is taken in a transaction, then its word is
//   read-modify-written while input is stalled. a byte that also
//   carries the end flag holds input off for a further pad merge.
//   the 64th byte of a block starts the round unit, which runs one
//   round per cycle, fed by the block memory's read port; while it runs,
//   input is stalled.
//   an end transaction pads with 0x80 and zeros (zeroing each remaining
//   word in turn), writes the bit length into words 14 and 15 and runs one
//   or two final compressions, then presents the digest on out_valid.
//   digest_low holds bytes 0..7, digest_high bytes 8..15.
//   while out_stall holds the digest, no further input is taken.
//   reset clears the byte count and restores the initial chaining value;
//   the block memory needs no clearing.
module md5_message_digest (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] digest_low,
    output logic [63:0] digest_high
);
    md5_pkg::state_t state_reg, state_next;
    logic [60:0] count_reg, count_next;
    logic [3:0]  pw_reg, pw_next;       // padding word pointer
    logic        fin_reg, fin_next;     // last compression of the message
    logic        two_reg, two_next;     // tail needs a second block
    logic        lanes_reg, lanes_next; // read of current word pending
    logic [7:0]  byte_reg;
    logic        endp_reg, endp_next;
    logic        pend_reg, pend_next;

    logic        we;
    logic [3:0]  waddr, raddr, word_addr;
    logic [31:0] wdata, rdata;
    logic        start, reinit, done;
    md5_pkg::comp_ctl_t ctl;
    logic [127:0] chain;
    logic [63:0] bits;
    logic [5:0]  pos;
    logic [31:0] merged;
    logic [1:0]  lane;

    assign pos  = count_reg[5:0];
    assign lane = pos[1:0];
    assign bits = {count_reg, 3'b000};

    always_comb
    begin
        merged = rdata;
        case (lane)
            2'd0: merged[7:0]   = byte_reg;
            2'd1: merged[15:8]  = byte_reg;
            2'd2: merged[23:16] = byte_reg;
            default: merged[31:24] = byte_reg;
        endcase
        // padding clears the lanes above the pad byte
        if (endp_reg)
        begin
            case (lane)
                2'd0: merged[31:8]  = '0;
                2'd1: merged[31:16] = '0;
                2'd2: merged[31:24] = '0;
                default: ;
            endcase
        end
    end

    md5_ram #(.WIDTH(32), .DEPTH(16)) u_blk (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    md5_round u_round (
        .clk(clk), .rst_n(rst_n), .start(start), .reinit(reinit),
        .word(rdata), .word_addr(word_addr), .done(done), .ctl(ctl), .chain(chain)
    );

    // accept only in idle with no pending merge or pad
    assign in_stall  = !(state_reg == md5_pkg::ST_IDLE && !lanes_reg && !pend_reg);
    assign out_valid = (state_reg == md5_pkg::ST_OUT);
    assign digest_low  = chain[63:0];
    assign digest_high = chain[127:64];

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pw_next    = pw_reg;
        fin_next   = fin_reg;
        two_next   = two_reg;
        lanes_next = 1'b0;
        endp_next  = endp_reg;
        we = 1'b0; waddr = pos[5:2]; wdata = merged;
        raddr = ctl.busy ? word_addr : pos[5:2];
        start = 1'b0; reinit = 1'b0;
        unique case (state_reg)
            md5_pkg::ST_IDLE:
            begin
                if (lanes_reg)
                begin
                    // merge byte (data or pad) into its word
                    we = 1'b1;
                    if (!endp_reg)
                        count_next = count_reg + 61'd1;
                    if (!endp_reg && pos == md5_pkg::LAST_POS)
                    begin
                        start = 1'b1;
                        fin_next = 1'b0;
                        state_next = md5_pkg::ST_COMP;
                    end
                    else if (endp_reg)
                    begin
                        two_next = (pos > md5_pkg::MAX_TAIL);
                        pw_next = pos[5:2] + 4'd1;
                        if (pos[5:2] == 4'd15)
                            state_next = (pos > md5_pkg::MAX_TAIL) ? md5_pkg::ST_COMP
                                                                   : md5_pkg::ST_LEN_LO;
                        else
                            state_next = md5_pkg::ST_PAD;
                        if (pos[5:2] == 4'd15 && pos > md5_pkg::MAX_TAIL)
                        begin
                            start = 1'b1;
                            fin_next = 1'b0;
                        end
                    end
                    else if (endp_next)
                        lanes_next = 1'b0;
                end
                // second pass for a pending end after a data byte
                if (lanes_reg && !endp_reg && endp_next && pos != md5_pkg::LAST_POS)
                begin
                    lanes_next = 1'b1;
                end
            end
            md5_pkg::ST_PAD:
            begin
                we = 1'b1; waddr = pw_reg; wdata = '0;
                pw_next = pw_reg + 4'd1;
                if (pw_reg == 4'd15)
                begin
                    if (two_reg)
                    begin
                        start = 1'b1;
                        fin_next = 1'b0;
                        state_next = md5_pkg::ST_COMP;
                    end
                    else
                        state_next = md5_pkg::ST_LEN_LO;
                end
            end
            md5_pkg::ST_LEN_LO:
            begin
                we = 1'b1; waddr = 4'd14; wdata = bits[31:0];
                state_next = md5_pkg::ST_LEN_HI;
            end
            md5_pkg::ST_LEN_HI:
            begin
                we = 1'b1; waddr = 4'd15; wdata = bits[63:32];
                start = 1'b1;
                fin_next = 1'b1;
                state_next = md5_pkg::ST_COMP;
            end
            md5_pkg::ST_COMP:
            begin
                if (done)
                begin
                    if (fin_reg)
                        state_next = md5_pkg::ST_OUT;
                    else if (endp_reg)
                    begin
                        // second tail block: zero words 0..15 before the length is written
                        two_next = 1'b0;
                        pw_next = 4'd0;
                        state_next = md5_pkg::ST_PAD;
                    end
                    else
                    begin
                        state_next = md5_pkg::ST_IDLE;
                        // end flag came with the 64th byte
                        if (fin_reg == 1'b0 && endp_next)
                            lanes_next = 1'b0;
                    end
                end
            end
            md5_pkg::ST_OUT:
            begin
                if (!out_stall)
                begin
                    reinit = 1'b1;
                    count_next = '0;
                    endp_next = 1'b0;
                    state_next = md5_pkg::ST_IDLE;
                end
            end
            default: state_next = md5_pkg::ST_IDLE;
        endcase
        // the first round's word is fetched in the start cycle
        if (start)
            raddr = word_addr;
        if (in_valid && !in_stall)
        begin
            if (has_byte)
            begin
                lanes_next = 1'b1;
                endp_next = 1'b0;
            end
            else if (end_of_message)
            begin
                lanes_next = 1'b1;
                endp_next = 1'b1;
            end
        end
    end

    // pad-after-data: remember the end flag of a byte transaction
    always_comb
    begin
        pend_next = pend_reg;
        if (in_valid && !in_stall)
            pend_next = has_byte && end_of_message;
        else if (pend_reg && state_reg == md5_pkg::ST_IDLE && !lanes_reg)
            pend_next = 1'b0;
    end

    logic issue_pad;
    assign issue_pad = pend_reg && state_reg == md5_pkg::ST_IDLE && !lanes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= md5_pkg::ST_IDLE;
            count_reg <= '0;
            pw_reg    <= '0;
            fin_reg   <= 1'b0;
            two_reg   <= 1'b0;
            lanes_reg <= 1'b0;
            endp_reg  <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pw_reg    <= pw_next;
            fin_reg   <= fin_next;
            two_reg   <= two_next;
            pend_reg  <= pend_next;
            if (issue_pad)
            begin
                lanes_reg <= 1'b1;
                endp_reg  <= 1'b1;
            end
            else
            begin
                lanes_reg <= lanes_next;
                endp_reg  <= endp_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            byte_reg <= has_byte ? data_byte : md5_pkg::PAD_BYTE;
        else if (issue_pad)
            byte_reg <= md5_pkg::PAD_BYTE;
    end

    logic unused_ok;
    assign unused_ok = ctl.start;
endmodule

// ----- dv/md5_digest_checker.sv -----
// ---------------------------------------------------------------------------
// md5 digest checker
// watches both channels, hashes accepted bytes and compares each digest
// ---------------------------------------------------------------------------
module md5_digest_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        end_of_message,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [63:0] digest_low,
    input  logic [63:0] digest_high,
    output int          fail_count,
    output int          pending_digests
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [63:0] lo;
        logic [63:0] hi;
    } digest_t;

    logic [31:0] chain [4];
    logic [31:0] blk [16];
    logic [60:0] nbytes;
    digest_t digest_q [$];

    localparam logic [31:0] SINE_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    localparam int ROT [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

    function automatic void restart_chain();
        chain[0] = md5_pkg::IV_A;
        chain[1] = md5_pkg::IV_B;
        chain[2] = md5_pkg::IV_C;
        chain[3] = md5_pkg::IV_D;
        foreach (blk[i]) blk[i] = '0;
        nbytes = '0;
    endfunction

    function automatic void compress();
        logic [31:0] a, b, c, d, f, t;
        int w, s;
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        for (int r = 0; r < 64; r++)
        begin
            s = ROT[((r >> 4) << 2) | (r & 3)];
            if (r < 16)
            begin
                f = (b & c) | (~b & d); w = r;
            end
            else if (r < 32)
            begin
                f = (d & b) | (~d & c); w = (5 * r + 1) & 15;
            end
            else if (r < 48)
            begin
                f = b ^ c ^ d; w = (3 * r + 5) & 15;
            end
            else
            begin
                f = c ^ (b | ~d); w = (7 * r) & 15;
            end
            t = a + f + blk[w] + SINE_K[r];
            t = (t << s) | (t >> (32 - s));
            a = d; d = c; c = b; b = b + t;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    endfunction

    function automatic void put_byte(int pos, logic [7:0] v);
        blk[pos >> 2][(pos & 3) * 8 +: 8] = v;
    endfunction

    function automatic void absorb_item(logic [7:0] db, logic hb, logic eom);
        int pos;
        logic [63:0] bits;
        if (hb)
        begin
            pos = int'(nbytes[5:0]);
            put_byte(pos, db);
            nbytes = nbytes + 1'b1;
            if (pos == 63) compress();
        end
        if (!eom) return;
        pos = int'(nbytes[5:0]);
        bits = {nbytes, 3'b000};
        put_byte(pos, md5_pkg::PAD_BYTE);
        for (int p = pos + 1; p < 64; p++) put_byte(p, 8'h00);
        if (pos > 55)
        begin
            compress();
            foreach (blk[i]) blk[i] = '0;
        end
        blk[14] = bits[31:0];
        blk[15] = bits[63:32];
        compress();
        digest_q.push_back('{lo: {chain[1], chain[0]}, hi: {chain[3], chain[2]}});
        restart_chain();
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        digest_t want;
        if (!rst_n)
        begin
            restart_chain();
            digest_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                absorb_item(data_byte, has_byte, end_of_message);
            if (out_valid && !out_stall)
            begin
                if (digest_q.size() == 0)
                begin
                    $error("digest transaction with none expected");
                    fail_count++;
                end
                else
                begin
                    want = digest_q.pop_front();
                    if (digest_low !== want.lo)
                    begin
                        $error("digest_low expected %h actual %h", want.lo, digest_low);
                        fail_count++;
                    end
                    if (digest_high !== want.hi)
                    begin
                        $error("digest_high expected %h actual %h", want.hi, digest_high);
                        fail_count++;
                    end
                end
            end
        end
        pending_digests = digest_q.size();
    end
endmodule

// ----- dv/md5_message_digest_tb.sv -----
// ---------------------------------------------------------------------------
// md5 message digest testbench
// streams directed and random messages with random gaps and stalls
// ---------------------------------------------------------------------------
module md5_message_digest_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = '0;
    logic        has_byte = 1'b0;
    logic        end_of_message = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] digest_low;
    logic [63:0] digest_high;
    int          fail_count;
    int          pending_digests;
    int          cycles = 0;
    bit          no_gaps = 1'b0;

    always #5 clk = ~clk;

    md5_message_digest i_dut (.*);

    md5_digest_checker i_checker (.*);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver stall: random hold lengths, none while no_gaps is set
    initial
    begin
        int n;
        forever
        begin
            @(posedge clk);
            n = no_gaps ? 0 : $urandom_range(0, 9);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    task automatic send(input logic [7:0] db, input logic hb, input logic eom);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= db;
        has_byte <= hb;
        end_of_message <= eom;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_message(input int len, input bit end_with_byte);
        int body;
        body = end_with_byte && len > 0 ? len - 1 : len;
        for (int i = 0; i < body; i++)
        begin
            if ($urandom_range(0, 15) == 0) send(8'($urandom), 1'b0, 1'b0);
            send(8'($urandom), 1'b1, 1'b0);
        end
        if (end_with_byte && len > 0) send(8'($urandom), 1'b1, 1'b1);
        else send(8'($urandom), 1'b0, 1'b1);
    endtask

    initial
    begin
        int sent;
        int len;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // empty message, idle item, byte extremes
        send(8'h00, 1'b0, 1'b0);
        send(8'hFF, 1'b0, 1'b1);
        send(8'h00, 1'b1, 1'b0);
        send(8'hFF, 1'b1, 1'b1);
        send(8'hA5, 1'b1, 1'b0);
        send(8'h5A, 1'b0, 1'b1);
        // tail over 55 bytes, and exact block
        send_message(56, 1'b1);
        send_message(64, 1'b0);
        // back to back with no gaps or stalls
        no_gaps = 1'b1;
        send_message(55, 1'b1);
        send_message(3, 1'b0);
        no_gaps = 1'b0;
        sent = 0;
        while (sent < 1000)
        begin
            case ($urandom_range(0, 3))
                0: len = $urandom_range(0, 8);
                1: len = $urandom_range(50, 70);
                2: len = $urandom_range(110, 130);
                default: len = $urandom_range(0, 200);
            endcase
            no_gaps = ($urandom_range(0, 7) == 0);
            send_message(len, 1'($urandom));
            sent += len + 1;
        end
        no_gaps = 1'b0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_digests != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// ----- md5_message_digest.f -----
hdl/md5_pkg.sv
hdl/md5_ram.sv
hdl/md5_round.sv
hdl/md5_message_digest.sv
dv/md5_digest_checker.sv
dv/md5_message_digest_tb.sv
